// File: design/bpa_pkg.sv
// Shared types for the bitmap page allocator: action and status codes,
// controller states and the command/status bundles between control and datapath.
// No dependencies.
package bpa_pkg;

  typedef enum logic [1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_SET_FREE = 2'd2,
    ACT_SET_USED = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NO_FREE = 2'd1,
    STS_RANGE   = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_RANGE,
    OP_RECOUNT
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_RD,
    S_EX,
    S_FLUSH,
    S_RESP
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic take;
    logic start_recount;
    logic div;
    logic rd;
    logic ex;
    logic load;
  } bpa_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pend;
    logic bad;
    logic empty;
    logic last;
    logic hit;
    logic recount;
    logic out_busy;
  } bpa_sts_t;

endpackage

// File: design/bpa_ctrl.sv
// Controller for the bitmap page allocator: sequences the clearing pass,
// the word walk of each action and recount, and the result load. Uses bpa_pkg.
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  input  bpa_sts_t sts,
  output bpa_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (sts.pend || in_tvalid) state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.bad || sts.empty) state_nxt = S_FLUSH;
        else                      state_nxt = S_RD;
      end
      S_RD: begin
        state_nxt = S_EX;
      end
      S_EX: begin
        if (sts.hit || sts.last) state_nxt = S_FLUSH;
        else                     state_nxt = S_RD;
      end
      S_FLUSH: begin
        if (sts.recount) state_nxt = S_IDLE;
        else             state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        // a pending recount goes ahead of new words
        in_tready         = !sts.pend;
        cmd.start_recount = sts.pend;
        cmd.take          = !sts.pend && in_tvalid;
      end
      S_DIV:   cmd.div  = 1'b1;
      S_RD:    cmd.rd   = 1'b1;
      S_EX:    cmd.ex   = 1'b1;
      S_FLUSH: ;
      S_RESP:  cmd.load = !sts.out_busy;
      default: ;
    endcase
  end

endmodule

// File: design/bpa_dpath.sv
// Datapath for the bitmap page allocator: used-bit map memory, word walk
// registers, free counter, limit register and the result register. Uses bpa_pkg.
module bpa_dpath
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  bpa_cmd_t        cmd,
  output bpa_sts_t        sts,
  input  logic [1:0]      item_action,
  input  logic [15:0]     item_page,
  input  logic [16:0]     item_count,
  input  logic            cfg_we,
  input  logic [16:0]     cfg_wdata,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      out_status,
  output logic [15:0]     out_alloc_page,
  output logic [16:0]     out_free_pages
);

  localparam int STORE_PAGES = (NUM_PAGES < 65536) ? NUM_PAGES : 65536;
  localparam int STORE_WORDS = (STORE_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
  localparam int CNT_W       = $clog2(WORD_BITS + 1);
  localparam int IDX_W       = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam int RSHIFT      = 24;
  localparam int RECIP       = ((1 << RSHIFT) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECIP_W     = $clog2(RECIP + 1);
  localparam int PROD_W      = 16 + RECIP_W;

  localparam logic [17:0]      WB18    = 18'(WORD_BITS);
  localparam logic [17:0]      STORE18 = 18'(STORE_PAGES);
  localparam logic [CNT_W-1:0] WBN     = CNT_W'(WORD_BITS);

  function automatic logic [WORD_BITS-1:0] therm(input logic [CNT_W-1:0] n);
    logic [WORD_BITS-1:0] m;
    for (int j = 0; j < WORD_BITS; j++) begin
      m[j] = (CNT_W'(j) < n);
    end
    return m;
  endfunction

  function automatic logic [CNT_W-1:0] popcnt(input logic [WORD_BITS-1:0] v);
    logic [CNT_W-1:0] s;
    s = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      s = s + CNT_W'(v[j]);
    end
    return s;
  endfunction

  logic [WORD_BITS-1:0] mem [STORE_WORDS];

  op_t                  op_r;
  logic                 set_used_r;
  logic [15:0]          page_r;
  logic [16:0]          cnt_r;
  logic [17:0]          end_r;
  logic [PROD_W-1:0]    prod_r;
  logic [ADDR_W-1:0]    word_r;
  logic [17:0]          base_r;
  logic [WORD_BITS-1:0] rd_data_r;
  logic [WORD_BITS-1:0] chg_r, chg_nxt;
  logic                 chg_up_r, chg_up_nxt;
  logic [16:0]          counter_r;
  logic                 found_r;
  logic [15:0]          grant_r;
  logic [16:0]          total_r;
  logic                 pend_r;
  logic [ADDR_W-1:0]    clr_addr_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [15:0]          out_page_r;
  logic [16:0]          out_free_r;

  logic [16:0]          limit;
  logic [17:0]          lim18, start18;
  logic [CNT_W-1:0]     lim_n, lo_n, hi_n;
  logic [WORD_BITS-1:0] lim_mask, rng_mask, free_vec, first_free, new_word;
  logic [IDX_W-1:0]     first_idx;
  logic                 hit, last, bad, wr_en;
  logic [CNT_W-1:0]     delta;
  logic [ADDR_W-1:0]    start_word;
  status_t              res_status;

  assign limit   = (total_r > STORE18[16:0]) ? STORE18[16:0] : total_r;
  assign lim18   = {1'b0, limit};
  assign start18 = {2'b0, page_r};

  // bits of the current word below the search limit, and the range start and end within it
  always_comb begin
    if (lim18 <= base_r)                lim_n = '0;
    else if (lim18 - base_r >= WB18)    lim_n = WBN;
    else                                lim_n = CNT_W'(lim18 - base_r);
    if (start18 > base_r)               lo_n = CNT_W'(start18 - base_r);
    else                                lo_n = '0;
    if (end_r - base_r >= WB18)         hi_n = WBN;
    else                                hi_n = CNT_W'(end_r - base_r);
  end

  assign lim_mask   = therm(lim_n);
  assign rng_mask   = therm(hi_n) & ~therm(lo_n);
  assign free_vec   = ~rd_data_r & lim_mask;
  assign first_free = free_vec & (~free_vec + 1'b1);

  always_comb begin
    first_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (first_free[j]) first_idx = first_idx | IDX_W'(j);
    end
  end

  assign hit  = (op_r == OP_ALLOC) && (free_vec != '0);
  assign last = (op_r == OP_RANGE) ? (end_r <= base_r + WB18) : (lim18 <= base_r + WB18);
  assign bad  = (op_r == OP_RANGE) && (end_r > STORE18);

  always_comb begin
    new_word   = rd_data_r;
    chg_nxt    = '0;
    chg_up_nxt = 1'b0;
    wr_en      = 1'b0;
    if (cmd.ex) begin
      case (op_r)
        OP_ALLOC: begin
          new_word = rd_data_r | first_free;
          chg_nxt  = first_free;
          wr_en    = hit;
        end
        OP_RANGE: begin
          new_word   = set_used_r ? (rd_data_r | rng_mask) : (rd_data_r & ~rng_mask);
          chg_nxt    = (rd_data_r ^ new_word) & lim_mask;
          chg_up_nxt = !set_used_r;
          wr_en      = 1'b1;
        end
        default: begin
          chg_nxt    = free_vec;
          chg_up_nxt = 1'b1;
        end
      endcase
    end
  end

  assign delta      = popcnt(chg_r);
  assign start_word = ADDR_W'(prod_r >> RSHIFT);

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      mem[clr_addr_r] <= '1;
    end else if (wr_en) begin
      mem[word_r] <= new_word;
    end
    if (cmd.rd) begin
      rd_data_r <= mem[word_r];
    end
  end

  // walk, item and result registers
  always_ff @(posedge clk) begin
    chg_r    <= chg_nxt;
    chg_up_r <= chg_up_nxt;
    if (cmd.take) begin
      page_r  <= item_page;
      found_r <= 1'b0;
      grant_r <= '0;
      prod_r  <= PROD_W'(item_page) * PROD_W'(RECIP);
      unique case (action_t'(item_action))
        ACT_ALLOC: begin
          op_r       <= OP_ALLOC;
          set_used_r <= 1'b1;
          cnt_r      <= 17'd1;
          end_r      <= 18'(item_page) + 18'd1;
        end
        ACT_FREE: begin
          op_r       <= OP_RANGE;
          set_used_r <= 1'b0;
          cnt_r      <= 17'd1;
          end_r      <= 18'(item_page) + 18'd1;
        end
        ACT_SET_FREE, ACT_SET_USED: begin
          op_r       <= OP_RANGE;
          set_used_r <= (action_t'(item_action) == ACT_SET_USED);
          cnt_r      <= item_count;
          end_r      <= 18'(item_page) + 18'(item_count);
        end
        default: ;
      endcase
    end else if (cmd.start_recount) begin
      op_r <= OP_RECOUNT;
    end
    if (cmd.div) begin
      if (op_r == OP_RANGE) begin
        word_r <= start_word;
        base_r <= 18'(start_word) * WB18;
      end else begin
        word_r <= '0;
        base_r <= '0;
      end
    end else if (cmd.ex) begin
      word_r <= word_r + 1'b1;
      base_r <= base_r + WB18;
      if (hit) begin
        found_r <= 1'b1;
        grant_r <= 16'(base_r + 18'(first_idx));
      end
    end
    if (cmd.load) begin
      out_status_r <= res_status;
      out_page_r   <= grant_r;
      out_free_r   <= counter_r;
    end
  end

  always_comb begin
    if (bad)                             res_status = STS_RANGE;
    else if (op_r == OP_ALLOC && !found_r) res_status = STS_NO_FREE;
    else                                 res_status = STS_OK;
  end

  // control state: limit, recount request, free counter, clear sweep, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= 17'h10000;
      pend_r      <= 1'b0;
      counter_r   <= '0;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        total_r <= cfg_wdata;
        pend_r  <= 1'b1;
      end else if (cmd.start_recount) begin
        pend_r  <= 1'b0;
      end
      if (cmd.start_recount) begin
        counter_r <= '0;
      end else if (chg_up_r) begin
        counter_r <= counter_r + 17'(delta);
      end else begin
        counter_r <= counter_r - 17'(delta);
      end
      if (cmd.clear_step) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts            = '0;
    sts.clear_last = (clr_addr_r == ADDR_W'(STORE_WORDS - 1));
    sts.pend       = pend_r;
    sts.bad        = bad;
    sts.empty      = (op_r == OP_RANGE) ? (cnt_r == '0) : (limit == '0);
    sts.last       = last;
    sts.hit        = hit;
    sts.recount    = (op_r == OP_RECOUNT);
    sts.out_busy   = out_valid_r && !out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_alloc_page = out_page_r;
  assign out_free_pages = out_free_r;

endmodule

// File: design/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: first-fit page frame allocation over a
// used-bit map. Instantiates bpa_ctrl and bpa_dpath; uses bpa_pkg.
//
//   channel  direction  payload
//   in_      slave      tuser: action; tdata: page, count
//   out_     master     tuser: status; tdata: alloc_page, free_pages
//   cfg_     write only wdata: total_pages
//
// Each action walks map words, each with a memory read state (S_RD) and then
// a modify/write state (S_EX), plus setup (S_DIV), counter update (S_FLUSH)
// and result (S_RESP). Allocate stops at the first word with a free page below
// the limit; range actions touch ceil-spanned words only. A total_pages write
// starts a recount walk over the words below the limit. After reset a clearing
// pass over every map word (1024 at the default size) runs before any word is
// accepted. A result waiting on out_tready holds the block in its result stage.
module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int NUM_PAGES = 65536,
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] action
  input  logic [39:0] in_tdata,   // [15:0] page, [32:16] count, zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic [39:0] out_tdata,  // [15:0] alloc_page, [32:16] free_pages, zero fill
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata
);

  bpa_cmd_t    cmd;
  bpa_sts_t    sts;
  logic [15:0] res_page;
  logic [16:0] res_free;

  bpa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpa_dpath #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .item_action    (in_tuser),
    .item_page      (in_tdata[15:0]),
    .item_count     (in_tdata[32:16]),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_status     (out_tuser),
    .out_alloc_page (res_page),
    .out_free_pages (res_free)
  );

  assign out_tdata = {7'd0, res_free, res_page};

endmodule
